// File: hw/rtl/gpa_pkg.sv
// Shared types and constants for the gradient phase accumulator.
package gpa_pkg;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_MOVE  = 2'd2;

   localparam logic [31:0] SIGNAL_ONE = 32'h8000_0000;
   localparam logic [47:0] ELAPSED_MAX = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [1:0]         operation;
      logic [5:0]         entry_index;
      logic [31:0]        time_value;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic [31:0]        relax_rate;
   } req_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [31:0]        decay_signal;
      logic signed [63:0] accum_phase;
   } rsp_type;

   typedef logic [255:0][31:0] decay_table_type;

   // Saturating 64-bit signed add.
   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return s[63:0];
   endfunction

   // Saturate a 64-bit signed value into 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // exp(-y) in Q1.31 for y in [0, 1] with 52 fraction bits, series through the y^40 term
   function automatic logic [31:0] exp_neg_q52(input logic [63:0] y);
      logic [127:0] p;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic [63:0] r;
      term = 64'd1 << 52;
      sum = $signed(term);
      for (int j = 1; j <= 40; j++) begin
         if (term != '0) begin
            p = (128'(term) * 128'(y)) >> 52;
            term = p[63:0] / 64'(j);
            sum = j[0] ? sum - $signed(term) : sum + $signed(term);
         end
      end
      if (sum < 0) sum = '0;
      r = (64'(sum) + (64'd1 << 20)) >> 21;
      return (r > 64'h8000_0000) ? 32'h8000_0000 : r[31:0];
   endfunction

   // entry k holds exp(-k/256)
   function automatic decay_table_type build_decay_table();
      decay_table_type t;
      for (int k = 0; k < 256; k++)
         t[k] = exp_neg_q52(64'(k) << 44);
      return t;
   endfunction

   localparam decay_table_type DECAY_TABLE = build_decay_table();
   localparam logic [31:0] EXP_MINUS_ONE = exp_neg_q52(64'd1 << 52);

endpackage

// File: hw/rtl/gradient_phase_accumulator.sv
// Gradient phase accumulator: one spin particle under a piecewise gradient sequence.
// A load writes the entry RAMs on acceptance and the block stays idle. A start goes
// straight to the output state. A move walks one segment per sequence boundary crossed,
// plus the final one: it reads and checks the entry, then runs seven products on one shared
// 32x32 multiplier, each a launch state, the partial-product accumulation and a result state,
// plus a state each for the midpoint and the position update. Decay then adds a
// state for the table factor and one per whole e-fold (up to 31), and the output state
// loads the output register once it is free. A new item is taken as soon as the block is idle,
// even while the previous beat still waits on rsp_stall.
module gradient_phase_accumulator
   import gpa_pkg::*;
#(
   parameter int MAX_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int F = 16;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_WAIT, S_CHK, S_STEP, S_STEPW, S_MID, S_DOT, S_DOTW,
      S_PH, S_PHW, S_POS, S_DEC0, S_DEC1, S_OUT, S_MUL
   } state_type;

   state_type state_ff;
   state_type mul_ret_ff;
   logic [5:0] last_ff;
   logic [AW-1:0] cur_ff;
   logic [47:0] elapsed_ff, tfinal_ff, t_ff;
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] org_ff [3];
   logic signed [31:0] vel_ff [3];
   logic signed [63:0] step_ff [3];
   logic signed [63:0] mid_ff [3];
   logic signed [63:0] dot_ff, phase_ff, dt_ff;
   logic [31:0] sig_ff, dur_ff, rate_ff;
   logic [1:0] lane_ff;
   logic final_ff;
   logic [63:0] x_ff;
   logic [5:0] n_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   logic [63:0] mul_a_ff, mul_b_ff;
   logic mul_neg_ff, mul_frac_ff;
   logic [127:0] mul_acc_ff;
   logic [1:0] mul_cnt_ff;

   logic [31:0] t_rd;
   logic [95:0] g_rd;
   logic ram_we;
   logic [AW-1:0] last_eff;
   logic signed [31:0] g_lane;
   logic signed [63:0] op_a, op_b;
   logic [63:0] part;
   logic [127:0] acc_sum;
   logic [127:0] mag;
   logic signed [63:0] mul_res;

   assign ram_we = req_valid && !req_stall && req_data.operation == OP_LOAD
                   && 32'(req_data.entry_index) < MAX_ENTRIES;
   assign last_eff = (32'(last_ff) > MAX_ENTRIES - 1) ? AW'(MAX_ENTRIES - 1) : AW'(last_ff);

   gpa_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_times (
      .clock, .wr_en(ram_we), .wr_addr(AW'(req_data.entry_index)),
      .wr_data(req_data.time_value), .rd_addr(cur_ff), .rd_data(t_rd));
   gpa_ram #(.WIDTH(96), .DEPTH(MAX_ENTRIES)) u_grads (
      .clock, .wr_en(ram_we), .wr_addr(AW'(req_data.entry_index)),
      .wr_data({req_data.vec_z, req_data.vec_y, req_data.vec_x}),
      .rd_addr(cur_ff), .rd_data(g_rd));

   assign g_lane = (lane_ff == 2'd0) ? g_rd[31:0] : (lane_ff == 2'd1) ? g_rd[63:32] : g_rd[95:64];

   // operands of the product launched from this state
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         S_STEP: begin
            op_a = 64'(vel_ff[lane_ff]);
            op_b = dt_ff;
         end
         S_DOT: begin
            op_a = 64'(g_lane);
            op_b = mid_ff[lane_ff];
         end
         S_PH: begin
            op_a = dt_ff;
            op_b = dot_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // one 32x32 partial product per cycle on the operand magnitudes
   assign part = 64'(mul_cnt_ff[1] ? mul_a_ff[63:32] : mul_a_ff[31:0])
               * 64'(mul_cnt_ff[0] ? mul_b_ff[63:32] : mul_b_ff[31:0]);

   always_comb begin
      case (mul_cnt_ff)
         2'd0:    acc_sum = mul_acc_ff + 128'(part);
         2'd3:    acc_sum = mul_acc_ff + (128'(part) << 64);
         default: acc_sum = mul_acc_ff + (128'(part) << 32);
      endcase
   end

   // shift, truncate toward zero and saturate the finished magnitude
   assign mag = mul_frac_ff ? (mul_acc_ff >> F) : mul_acc_ff;
   always_comb begin
      if (mag[127:64] != '0 ||
          mag[63:0] > (mul_neg_ff ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF))
         mul_res = mul_neg_ff ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      else
         mul_res = mul_neg_ff ? -$signed(mag[63:0]) : $signed(mag[63:0]);
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? 32'(last_ff) : '0;

   logic [63:0] dec;
   always_comb begin
      dec = '0;
      if (state_ff == S_DEC0)
         dec = (64'(sig_ff) * 64'(DECAY_TABLE[x_ff[31:24]])) >> 31;
      else if (state_ff == S_DEC1)
         dec = (64'(sig_ff) * 64'(EXP_MINUS_ONE)) >> 31;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff <= '0;
         cur_ff <= '0;
         elapsed_ff <= '0;
         phase_ff <= '0;
         sig_ff <= SIGNAL_ONE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            org_ff[i] <= '0;
         end
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
            last_ff <= csr_pwdata[5:0];
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_valid && !req_stall) begin
               if (req_data.operation == OP_START) begin
                  pos_ff[0] <= req_data.vec_x; pos_ff[1] <= req_data.vec_y;
                  pos_ff[2] <= req_data.vec_z;
                  org_ff[0] <= req_data.vec_x; org_ff[1] <= req_data.vec_y;
                  org_ff[2] <= req_data.vec_z;
                  phase_ff <= '0; elapsed_ff <= '0; cur_ff <= '0;
                  sig_ff <= SIGNAL_ONE;
                  state_ff <= S_OUT;
               end else if (req_data.operation == OP_MOVE) begin
                  vel_ff[0] <= req_data.vec_x; vel_ff[1] <= req_data.vec_y;
                  vel_ff[2] <= req_data.vec_z;
                  dur_ff <= req_data.time_value;
                  rate_ff <= req_data.relax_rate;
                  t_ff <= elapsed_ff;
                  tfinal_ff <= ({1'b0, elapsed_ff} + 49'(req_data.time_value)) > 49'(ELAPSED_MAX)
                               ? ELAPSED_MAX : elapsed_ff + 48'(req_data.time_value);
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_WAIT;   // address presented, data next cycle
            S_WAIT: state_ff <= S_CHK;
            S_CHK: begin
               lane_ff <= '0;
               if (cur_ff < last_eff && 48'(t_rd) < tfinal_ff) begin
                  dt_ff <= $signed({16'd0, 48'(t_rd)}) - $signed({16'd0, t_ff});
                  final_ff <= 1'b0;
               end else begin
                  dt_ff <= $signed({16'd0, tfinal_ff}) - $signed({16'd0, t_ff});
                  final_ff <= 1'b1;
               end
               dot_ff <= '0;
               state_ff <= S_STEP;
            end
            S_STEP, S_DOT, S_PH: begin
               mul_a_ff <= op_a[63] ? -op_a : op_a;
               mul_b_ff <= op_b[63] ? -op_b : op_b;
               mul_neg_ff <= op_a[63] ^ op_b[63];
               mul_frac_ff <= (state_ff != S_PH);
               mul_acc_ff <= '0;
               mul_cnt_ff <= '0;
               mul_ret_ff <= (state_ff == S_STEP) ? S_STEPW :
                             (state_ff == S_DOT) ? S_DOTW : S_PHW;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               mul_acc_ff <= acc_sum;
               mul_cnt_ff <= mul_cnt_ff + 2'd1;
               if (mul_cnt_ff == 2'd3) state_ff <= mul_ret_ff;
            end
            S_STEPW: begin
               step_ff[lane_ff] <= mul_res;
               lane_ff <= (lane_ff == 2'd2) ? 2'd0 : lane_ff + 2'd1;
               state_ff <= (lane_ff == 2'd2) ? S_MID : S_STEP;
            end
            S_MID: begin
               for (int i = 0; i < 3; i++)
                  mid_ff[i] <= sat_add64(64'(pos_ff[i]), step_ff[i] / 2);
               state_ff <= S_DOT;
            end
            S_DOTW: begin
               dot_ff <= sat_add64(dot_ff, mul_res);
               lane_ff <= (lane_ff == 2'd2) ? 2'd0 : lane_ff + 2'd1;
               state_ff <= (lane_ff == 2'd2) ? S_PH : S_DOT;
            end
            S_PHW: begin
               phase_ff <= sat_add64(phase_ff, mul_res);
               state_ff <= S_POS;
            end
            S_POS: begin
               for (int i = 0; i < 3; i++)
                  pos_ff[i] <= sat32(sat_add64(64'(pos_ff[i]), step_ff[i]));
               if (final_ff) begin
                  elapsed_ff <= tfinal_ff;
                  x_ff <= 64'(dur_ff) * 64'(rate_ff);
                  state_ff <= S_DEC0;
               end else begin
                  t_ff <= 48'(t_rd);
                  cur_ff <= cur_ff + 1'b1;
                  state_ff <= S_READ;
               end
            end
            S_DEC0: begin
               if (x_ff[63:32] >= 32) begin
                  sig_ff <= '0;
                  state_ff <= S_OUT;
               end else begin
                  sig_ff <= dec[31:0];
                  n_ff <= x_ff[37:32];
                  state_ff <= (x_ff[37:32] == 0) ? S_OUT : S_DEC1;
               end
            end
            S_DEC1: begin
               sig_ff <= dec[31:0];
               n_ff <= n_ff - 1'b1;
               if (n_ff == 6'd1) state_ff <= S_OUT;
            end
            // hold until the output register is free
            S_OUT: if (!rsp_valid_ff || !rsp_stall) begin
               rsp_ff.origin_x <= org_ff[0]; rsp_ff.origin_y <= org_ff[1];
               rsp_ff.origin_z <= org_ff[2];
               rsp_ff.pos_x <= pos_ff[0]; rsp_ff.pos_y <= pos_ff[1];
               rsp_ff.pos_z <= pos_ff[2];
               rsp_ff.decay_signal <= sig_ff;
               rsp_ff.accum_phase <= phase_ff;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_sig_le_one: assert property (@(posedge clock) disable iff (reset)
      sig_ff <= SIGNAL_ONE) else $error("signal above one");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall) else $error("accept while busy");
   a_cur_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cur_ff) < MAX_ENTRIES) else $error("entry index out of range");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled beat changed");
`endif
endmodule

// File: hw/rtl/gpa_ram.sv
// Generic single-port-write, registered-read RAM.
module gpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
